// ----- sv/rcr_pkg.sv -----
// ----------------------------------------------------------------------------
// rcr_pkg: shared definitions of the rectangle canvas rasterizer
// Word layouts, command and status codes, controller states and the
// control and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rcr_pkg;

  // Stream word widths.
  localparam int S_TDATA_W = 112;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 16;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Field widths of an input word.
  localparam int COORD_W = 20;
  localparam int CODE_W  = 8;
  localparam int RDPOS_W = 9;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;

  // Bit positions inside the input tdata word.
  localparam int X_LSB     = 0;
  localparam int Y_LSB     = 20;
  localparam int W_LSB     = 40;
  localparam int H_LSB     = 60;
  localparam int PAINT_LSB = 80;
  localparam int RROW_LSB  = 88;
  localparam int RCOL_LSB  = 97;

  // Bit positions inside the input tuser word.
  localparam int MODE_LSB   = 0;
  localparam int FILLED_BIT = 2;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD_SIZE  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_PAINT = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_OUTSIDE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd2;

  // Paint codes that a draw refuses.
  localparam logic [CODE_W-1:0] PAINT_NUL     = 8'd0;
  localparam logic [CODE_W-1:0] PAINT_NEWLINE = 8'd10;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 10'd1;
  localparam logic [CODE_W-1:0]     BG_RESET  = 8'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SETUP1,
    ST_SETUP2,
    ST_SWEEP,
    ST_READ,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup1;
    logic setup2;
    logic sweep_step;
    logic read_en;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [STAT_W-1:0] code;
    logic              sweep_last;
    logic              out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ----- sv/rectangle_canvas_rasterizer_core.sv -----
// ----------------------------------------------------------------------------
// rectangle_canvas_rasterizer_core: character canvas with rectangle drawing
// Clears the canvas, draws filled or outlined rectangles in fixed point
// and reads single pixels; one result word for every command word.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Fields (lowest bit first)
//   s_axis   in         tuser: mode, filled
//                       tdata: rect_x, rect_y, rect_w, rect_h, paint_code,
//                              read_row, read_col
//   m_axis   out        tdata: status, pixel_code
//   cfg      in         cfg_index 0 width, 1 height, 2 background code
//
// Clear and draw step the sweep over the active W by H canvas, one pixel
// a cycle, writing through the memory's write port; read and rejected
// commands skip the sweep.
// Commands are taken one at a time; a finished word waits in the output
// register while the next command is taken. A stalled output holds the
// result and the sequencer in its last step. Reset is synchronous and
// leaves the canvas contents undefined until a clear.
`default_nettype none

module rectangle_canvas_rasterizer_core #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [rcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [rcr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // rect_x, rect_y, rect_w, rect_h, paint_code, read_row, read_col, pad
  input  wire  [rcr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // mode, filled
  input  wire  [rcr_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // status, pixel_code, pad
  output logic [rcr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import rcr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Command sequencer.
  rcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Canvas datapath.
  rcr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- sv/rcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcr_ctrl: command sequencer of the rectangle canvas rasterizer
// Takes one command word at a time, steps the datapath through setup,
// the canvas sweep or the pixel read, and hands the result word over.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_ctrl (
  input  wire           clk,
  input  wire           rst,
  input  wire           in_valid,
  output logic          in_ready,
  input  rcr_pkg::stat_t stat,
  output rcr_pkg::cmd_t  cmd
);
  import rcr_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.mode)
          MODE_CLEAR: state_next = ST_SWEEP;
          MODE_DRAW:  state_next = (stat.code == STATUS_OK) ? ST_SETUP1 : ST_FINISH;
          MODE_READ:  state_next = (stat.code == STATUS_OK) ? ST_READ : ST_FINISH;
          default:    state_next = ST_FINISH;
        endcase
      end
      ST_SETUP1: begin
        cmd.setup1 = 1'b1;
        state_next = ST_SETUP2;
      end
      ST_SETUP2: begin
        cmd.setup2 = 1'b1;
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.read_en = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        // Wait until the output register can take the result word.
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/rcr_datapath.sv -----
// ----------------------------------------------------------------------------
// rcr_datapath: canvas memory, sweep counters and rectangle compares
// Holds the configuration registers, the captured command, the rectangle
// bounds, the row and column counters, the canvas memory and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_datapath #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [rcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [rcr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire  [rcr_pkg::S_TDATA_W-1:0]      in_data,
  input  wire  [rcr_pkg::S_TUSER_W-1:0]      in_user,
  input  rcr_pkg::cmd_t                      cmd,
  output rcr_pkg::stat_t                     stat,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [rcr_pkg::M_TDATA_W-1:0]      out_data
);
  import rcr_pkg::*;

  // Counter, dimension and compare widths.
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DWW   = $clog2(MAX_WIDTH + 1);
  localparam int DWH   = $clog2(MAX_HEIGHT + 1);
  localparam int PW0   = ((CW > RW) ? CW : RW) + FRAC_BITS + 1;
  localparam int PW    = (PW0 > COORD_W + 2) ? PW0 : COORD_W + 2;
  localparam int DEPTH = 2 ** (CW + RW);
  localparam logic signed [PW-1:0] ONE = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] canvas_width;
  logic [CFG_DATA_W-1:0] canvas_height;
  logic [CODE_W-1:0]     background_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= DIM_RESET;
      canvas_height   <= DIM_RESET;
      background_code <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:      canvas_width    <= cfg_data;
        CFG_HEIGHT:     canvas_height   <= cfg_data;
        CFG_BACKGROUND: background_code <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Canvas size saturated into the range the memory holds.
  logic [DWW-1:0] cw;
  logic [DWH-1:0] ch;

  assign cw = (canvas_width == '0) ? DWW'(1) :
              ((32'(canvas_width) > MAX_WIDTH) ? DWW'(MAX_WIDTH) : DWW'(canvas_width));
  assign ch = (canvas_height == '0) ? DWH'(1) :
              ((32'(canvas_height) > MAX_HEIGHT) ? DWH'(MAX_HEIGHT) : DWH'(canvas_height));

  // Fields of the incoming word.
  logic [MODE_W-1:0]         in_mode;
  logic                      in_filled;
  logic signed [COORD_W-1:0] in_w;
  logic signed [COORD_W-1:0] in_h;
  logic [CODE_W-1:0]         in_paint;
  logic [RDPOS_W-1:0]        in_row;
  logic [RDPOS_W-1:0]        in_col;
  logic [STAT_W-1:0]         in_code;

  assign in_mode   = in_user[MODE_LSB +: MODE_W];
  assign in_filled = in_user[FILLED_BIT];
  assign in_w      = in_data[W_LSB +: COORD_W];
  assign in_h      = in_data[H_LSB +: COORD_W];
  assign in_paint  = in_data[PAINT_LSB +: CODE_W];
  assign in_row    = in_data[RROW_LSB +: RDPOS_W];
  assign in_col    = in_data[RCOL_LSB +: RDPOS_W];

  // Status of a command, decided as it is taken.
  always_comb begin
    in_code = STATUS_OK;
    case (in_mode)
      MODE_DRAW: begin
        if (in_w[COORD_W-1] || (in_w == '0) || in_h[COORD_W-1] || (in_h == '0)) begin
          in_code = STATUS_BAD_SIZE;
        end else if ((in_paint == PAINT_NUL) || (in_paint == PAINT_NEWLINE)) begin
          in_code = STATUS_BAD_PAINT;
        end
      end
      MODE_READ: begin
        if ((32'(in_row) >= 32'(ch)) || (32'(in_col) >= 32'(cw))) begin
          in_code = STATUS_OUTSIDE;
        end
      end
      default: in_code = STATUS_OK;
    endcase
  end

  // Captured command.
  logic [MODE_W-1:0]         mode_r;
  logic                      filled_r;
  logic signed [COORD_W-1:0] rx;
  logic signed [COORD_W-1:0] ry;
  logic signed [COORD_W-1:0] rw;
  logic signed [COORD_W-1:0] rh;
  logic [CODE_W-1:0]         paint_r;
  logic [RW-1:0]             rd_row;
  logic [CW-1:0]             rd_col;
  logic [STAT_W-1:0]         code_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      filled_r <= in_filled;
      rx       <= in_data[X_LSB +: COORD_W];
      ry       <= in_data[Y_LSB +: COORD_W];
      rw       <= in_w;
      rh       <= in_h;
      paint_r  <= in_paint;
      rd_row   <= RW'(in_row);
      rd_col   <= CW'(in_col);
      code_r   <= in_code;
    end
  end

  // Rectangle bounds, in two add steps.
  logic signed [PW-1:0] sx, sy, sw, sh;
  logic signed [PW-1:0] xl, xr, yt, yb;
  logic signed [PW-1:0] xl1, yt1, xr1, yb1;

  assign sx = PW'(rx);
  assign sy = PW'(ry);
  assign sw = PW'(rw);
  assign sh = PW'(rh);

  always_ff @(posedge clk) begin
    if (cmd.setup1) begin
      xl  <= sx;
      yt  <= sy;
      xr  <= sx + sw;
      yb  <= sy + sh;
      xl1 <= sx + ONE;
      yt1 <= sy + ONE;
    end
    if (cmd.setup2) begin
      xr1 <= xr - ONE;
      yb1 <= yb - ONE;
    end
  end

  // Sweep counters over the active canvas, row after row.
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          col_last, row_last;

  assign col_last = ((DWW'(col) + DWW'(1)) == cw);
  assign row_last = ((DWH'(row) + DWH'(1)) == ch);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col <= '0;
      row <= '0;
    end else if (cmd.sweep_step) begin
      if (col_last) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Pixel position in fixed point, compared with the bounds.
  logic signed [PW-1:0] px, py;
  logic                 hit, edge_hit, wr_en;
  logic [CODE_W-1:0]    wr_data;

  assign px       = PW'(col) << FRAC_BITS;
  assign py       = PW'(row) << FRAC_BITS;
  assign hit      = (px >= xl) && (px <= xr) && (py >= yt) && (py <= yb);
  assign edge_hit = (px < xl1) || (px > xr1) || (py < yt1) || (py > yb1);
  assign wr_en    = cmd.sweep_step &&
                    ((mode_r == MODE_CLEAR) || (hit && (filled_r || edge_hit)));
  assign wr_data  = (mode_r == MODE_CLEAR) ? background_code : paint_r;

  // Canvas memory: one write port for the sweep, one read port.
  logic [CODE_W-1:0] canvas [0:DEPTH-1];
  logic [CODE_W-1:0] rd_pixel;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      canvas[{row, col}] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      rd_pixel <= canvas[{rd_row, rd_col}];
    end
  end

  // Output register: holds one result word until it is taken.
  logic [STAT_W-1:0] out_code;
  logic [CODE_W-1:0] out_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_code  <= code_r;
      out_pixel <= ((mode_r == MODE_READ) && (code_r == STATUS_OK)) ? rd_pixel : '0;
    end
  end

  assign out_data = {{(M_TDATA_W - STAT_W - CODE_W){1'b0}}, out_pixel, out_code};

  // Status toward the controller.
  assign stat.mode       = mode_r;
  assign stat.code       = code_r;
  assign stat.sweep_last = col_last && row_last;
  assign stat.out_busy   = out_valid && !out_ready;

endmodule

`default_nettype wire

// ----- sv/rcr_checker.sv -----
// ----------------------------------------------------------------------------
// rcr_checker: port-level checks of the rectangle canvas rasterizer
// Tracks outstanding commands and checks result words against them.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [rcr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import rcr_pkg::*;

  logic [2:0] pending;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Commands taken whose result word has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
    end
  end

  // A stalled result word stays in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Every result word belongs to a command taken earlier.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 3'd0)
    else $error("result word without a command");

  // At most one command at work and one result waiting.
  a_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("too many commands outstanding");

  // Commands are taken one at a time.
  a_single: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("command taken while another is at work");

  // Only a successful command carries a pixel.
  a_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[STAT_W-1:0] != STATUS_OK)
      |-> m_axis_tdata[STAT_W +: CODE_W] == '0)
    else $error("pixel code set on a failed command");

endmodule

bind rectangle_canvas_rasterizer_core rcr_checker u_rcr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
